FILE: rtl/qapm_pkg.sv
package qapm_pkg;

  // Field widths
  localparam int unsigned AngW   = 16;
  localparam int unsigned IntW   = 21;
  localparam int unsigned GainW  = 16;
  localparam int unsigned DutyW  = 16;
  localparam int unsigned AxisW  = 41;
  localparam int unsigned MixW   = 46;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CfgW   = 48;
  localparam int unsigned NumMotors = 4;

  // Attitude limits in Q10.6 (one degree is 64 LSB)
  localparam logic [16:0] DeadBand = 17'd64;
  localparam logic [16:0] DGateHi  = 17'd1280;
  localparam logic [16:0] PrLimit  = 17'd3840;
  localparam logic [16:0] YawLimit = 17'd11520;
  localparam logic signed [21:0] IntHi = 22'sd640000;
  localparam logic signed [21:0] IntLo = -22'sd640000;

  // Mixer: floor((n + 48000) / 96000), range offset keeps the dividend positive
  localparam logic signed [45:0] MixOffset = 46'sd6291504000;
  localparam logic signed [45:0] MixRange  = 46'sd12582912000;

  // 96000 is 256 * 375: floor(y / 375) for y below 2**26 is (y * MixRecip) >> 35
  localparam int unsigned        DivInW    = 26;
  localparam int unsigned        RecipW    = 27;
  localparam int unsigned        ProdW     = 53;
  localparam int unsigned        QuoW      = 18;
  localparam int unsigned        MixShift  = 35;
  localparam logic [RecipW-1:0]  MixRecip  = 27'd91625969;

  // Mixer signs, one bit per motor, set means add
  localparam logic [NumMotors-1:0] SignP = 4'b1001;
  localparam logic [NumMotors-1:0] SignR = 4'b1100;
  localparam logic [NumMotors-1:0] SignY = 4'b1010;

  localparam logic [DutyW-1:0] FaultDuty = 16'd8192;

  // Register reset values
  localparam logic [GainW-1:0] KpPitchRst = 16'd45056;
  localparam logic [GainW-1:0] KiPitchRst = 16'd205;
  localparam logic [GainW-1:0] KdPitchRst = 16'd9011;
  localparam logic [GainW-1:0] KpRollRst  = 16'd38912;
  localparam logic [GainW-1:0] KiRollRst  = 16'd225;
  localparam logic [GainW-1:0] KdRollRst  = 16'd9011;
  localparam logic [CfgW-1:0]  YawRst     = 48'd0;
  localparam logic [DutyW-1:0] BaseRst    = 16'd14746;

  typedef enum logic [IdxW-1:0] {
    RegKpPitch   = 4'd0,
    RegKiPitch   = 4'd1,
    RegKdPitch   = 4'd2,
    RegKpRoll    = 4'd3,
    RegKiRoll    = 4'd4,
    RegKdRoll    = 4'd5,
    RegYawGains  = 4'd6,
    RegBase      = 4'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    MxIdle,
    MxLoad,
    MxDiv,
    MxDone
  } mix_state_e;

  // Gains and mode of one axis lane
  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] ki;
    logic [GainW-1:0] kd;
    logic             yaw;
  } lane_cfg_t;

endpackage

FILE: rtl/qapm_lane.sv
module qapm_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             hold_i,
  input  logic signed [qapm_pkg::AngW-1:0] angle_i,
  input  logic signed [qapm_pkg::AngW-1:0] rate_i,
  input  qapm_pkg::lane_cfg_t              cfg_i,
  output logic                             env_fault_o,
  output logic                             valid_o,
  output logic signed [qapm_pkg::AxisW-1:0] axis_o
);
  import qapm_pkg::*;

  logic [16:0]              abs_a;
  logic                     below_db;
  logic signed [AngW-1:0]   err;
  logic [16:0]              abs_e;
  logic                     gate;
  logic signed [21:0]       int_sum;
  logic signed [IntW-1:0]   int_d;

  logic signed [IntW-1:0]   int_q;
  logic signed [AngW-1:0]   err_q;
  logic signed [AngW-1:0]   rate_q;
  logic                     kd_en_q;
  logic                     v1_q, v2_q, v3_q;
  logic signed [32:0]       pk_q;
  logic signed [37:0]       pi_q;
  logic signed [32:0]       pd_q;
  logic [GainW-1:0]         kd_eff;
  logic signed [AxisW-1:0]  d_term;
  logic signed [AxisW-1:0]  axis_d;
  logic signed [AxisW-1:0]  axis_q;

  // Magnitude, dead band, rate gain window and envelope fault
  always_comb begin
    abs_a = angle_i[AngW-1] ? (17'd0 - {1'b1, angle_i}) : {1'b0, angle_i};
    below_db = abs_a < DeadBand;
    err   = (!cfg_i.yaw && below_db) ? '0 : angle_i;
    abs_e = (!cfg_i.yaw && below_db) ? '0 : abs_a;
    gate  = cfg_i.yaw || ((abs_e > DeadBand) && (abs_e < DGateHi));
    env_fault_o = cfg_i.yaw ? (abs_a >= YawLimit) : (abs_a >= PrLimit);
  end

  // Integrate and clamp
  always_comb begin
    int_sum = {int_q[IntW-1], int_q} + {{(22-AngW){err[AngW-1]}}, err};
    if (int_sum > IntHi) begin
      int_d = IntHi[IntW-1:0];
    end else if (int_sum < IntLo) begin
      int_d = IntLo[IntW-1:0];
    end else begin
      int_d = int_sum[IntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (start_i && !hold_i) begin
        int_q <= int_d;
      end
    end
  end

  // Capture the sample terms
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      err_q   <= err;
      rate_q  <= rate_i;
      kd_en_q <= gate;
    end
  end

  assign kd_eff = kd_en_q ? cfg_i.kd : '0;

  // Form the three products
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      pk_q <= $signed({1'b0, cfg_i.kp}) * err_q;
      pi_q <= $signed({1'b0, cfg_i.ki}) * int_q;
      pd_q <= $signed({1'b0, kd_eff}) * rate_q;
    end
  end

  // Sum the axis output, rate term scaled by one degree and subtracted for yaw
  always_comb begin
    d_term = {{(AxisW-39){pd_q[32]}}, pd_q, 6'b000000};
    axis_d = {{(AxisW-33){pk_q[32]}}, pk_q} + {{(AxisW-38){pi_q[37]}}, pi_q};
    if (cfg_i.yaw) begin
      axis_d = axis_d - d_term;
    end else begin
      axis_d = axis_d + d_term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      axis_q <= axis_d;
    end
  end

  assign valid_o = v3_q;
  assign axis_o  = axis_q;

endmodule

FILE: rtl/qapm_mixer.sv
module qapm_mixer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              ack_i,
  input  logic signed [qapm_pkg::AxisW-1:0] p_i,
  input  logic signed [qapm_pkg::AxisW-1:0] r_i,
  input  logic signed [qapm_pkg::AxisW-1:0] y_i,
  input  logic [qapm_pkg::DutyW-1:0]        base_i,
  output logic                              done_o,
  output logic [qapm_pkg::DutyW-1:0]        duty_o [qapm_pkg::NumMotors]
);
  import qapm_pkg::*;

  mix_state_e state_q, state_d;
  logic ld_n, ld_div, step;

  logic signed [MixW-1:0] n_d   [NumMotors];
  logic signed [MixW-1:0] n_q   [NumMotors];
  logic signed [MixW-1:0] x_d   [NumMotors];
  logic [DivInW-1:0]      y_q   [NumMotors];
  logic [ProdW-1:0]       prod  [NumMotors];
  logic [QuoW-1:0]        quo_q [NumMotors];
  logic                   hi_q  [NumMotors];
  logic                   lo_q  [NumMotors];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MxIdle: if (start_i) state_d = MxLoad;
      MxLoad: state_d = MxDiv;
      MxDiv:  state_d = MxDone;
      MxDone: if (ack_i) state_d = MxIdle;
      default: state_d = MxIdle;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    ld_n   = 1'b0;
    ld_div = 1'b0;
    step   = 1'b0;
    done_o = 1'b0;
    unique case (state_q)
      MxIdle: ld_n = start_i;
      MxLoad: ld_div = 1'b1;
      MxDiv:  step = 1'b1;
      MxDone: done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MxIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Merge the three axes per motor: 5*(+-P +-R) + 3*(+-Y)
  always_comb begin
    logic signed [MixW-1:0] pe, re, ye, s;
    for (int k = 0; k < NumMotors; k++) begin
      pe = SignP[k] ? MixW'(p_i) : -MixW'(p_i);
      re = SignR[k] ? MixW'(r_i) : -MixW'(r_i);
      ye = SignY[k] ? MixW'(y_i) : -MixW'(y_i);
      s  = pe + re;
      n_d[k] = (s <<< 2) + s + (ye <<< 1) + ye;
      x_d[k] = n_q[k] + MixOffset;
    end
  end

  // Divide by 96000: drop the eight low bits, then multiply by the reciprocal of 375
  always_comb begin
    for (int k = 0; k < NumMotors; k++) begin
      prod[k] = {{(ProdW-DivInW){1'b0}}, y_q[k]} * {{(ProdW-RecipW){1'b0}}, MixRecip};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumMotors; k++) begin
      if (ld_n) begin
        n_q[k] <= n_d[k];
      end
      if (ld_div) begin
        lo_q[k] <= x_d[k][MixW-1];
        hi_q[k] <= x_d[k] >= MixRange;
        y_q[k]  <= x_d[k][33:8];
      end
      if (step) begin
        quo_q[k] <= prod[k][ProdW-1:MixShift];
      end
    end
  end

  // Add the base duty and saturate
  always_comb begin
    logic signed [18:0] sum;
    for (int k = 0; k < NumMotors; k++) begin
      sum = $signed({3'b000, base_i}) + $signed({1'b0, quo_q[k]}) - 19'sd65536;
      if (hi_q[k]) begin
        duty_o[k] = '1;
      end else if (lo_q[k] || sum[18]) begin
        duty_o[k] = '0;
      end else if (sum[17:16] != 2'b00) begin
        duty_o[k] = '1;
      end else begin
        duty_o[k] = sum[15:0];
      end
    end
  end

endmodule

FILE: rtl/quad_attitude_pid_mixer.sv
// Ready returns on the same edge that the result enters the output
// register, so the block takes no new sample while one is in flight.
// Each sample passes through the three-stage axis lanes and the merge,
// load, reciprocal multiply and done steps of the motor mixer; a stalled
// result holds off the next sample.
// Reset (asynchronous, active low) restores the gain registers, clears the
// integrators and the fault latch, and empties the output register.
module quad_attitude_pid_mixer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qapm_pkg::IdxW-1:0]         cfg_idx_i,
  input  logic [qapm_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [qapm_pkg::AngW-1:0]  pitch_angle_i,
  input  logic signed [qapm_pkg::AngW-1:0]  roll_angle_i,
  input  logic signed [qapm_pkg::AngW-1:0]  yaw_angle_i,
  input  logic signed [qapm_pkg::AngW-1:0]  pitch_rate_i,
  input  logic signed [qapm_pkg::AngW-1:0]  roll_rate_i,
  input  logic signed [qapm_pkg::AngW-1:0]  yaw_rate_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [qapm_pkg::DutyW-1:0]        motor_one_duty_o,
  output logic [qapm_pkg::DutyW-1:0]        motor_two_duty_o,
  output logic [qapm_pkg::DutyW-1:0]        motor_three_duty_o,
  output logic [qapm_pkg::DutyW-1:0]        motor_four_duty_o,
  output logic                              fault_tripped_o
);
  import qapm_pkg::*;

  logic [GainW-1:0] kp_pitch_q, ki_pitch_q, kd_pitch_q;
  logic [GainW-1:0] kp_roll_q, ki_roll_q, kd_roll_q;
  logic [CfgW-1:0]  yaw_gains_q;
  logic [DutyW-1:0] base_q;

  logic busy_q, fault_q, item_fault_q, out_valid_q;
  logic [DutyW-1:0] duty_q [NumMotors];
  logic fault_out_q;

  logic in_xfer, ack, mix_done;
  logic env_p, env_r, env_y, env_any;
  logic vp, vr, vy;
  logic signed [AxisW-1:0] ax_p, ax_r, ax_y;
  logic [DutyW-1:0] mix_duty [NumMotors];
  lane_cfg_t cfg_p, cfg_r, cfg_y;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_pitch_q  <= KpPitchRst;
      ki_pitch_q  <= KiPitchRst;
      kd_pitch_q  <= KdPitchRst;
      kp_roll_q   <= KpRollRst;
      ki_roll_q   <= KiRollRst;
      kd_roll_q   <= KdRollRst;
      yaw_gains_q <= YawRst;
      base_q      <= BaseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegKpPitch:  kp_pitch_q  <= cfg_wdata_i[GainW-1:0];
        RegKiPitch:  ki_pitch_q  <= cfg_wdata_i[GainW-1:0];
        RegKdPitch:  kd_pitch_q  <= cfg_wdata_i[GainW-1:0];
        RegKpRoll:   kp_roll_q   <= cfg_wdata_i[GainW-1:0];
        RegKiRoll:   ki_roll_q   <= cfg_wdata_i[GainW-1:0];
        RegKdRoll:   kd_roll_q   <= cfg_wdata_i[GainW-1:0];
        RegYawGains: yaw_gains_q <= cfg_wdata_i;
        RegBase:     base_q      <= cfg_wdata_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_p = '{kp: kp_pitch_q, ki: ki_pitch_q, kd: kd_pitch_q, yaw: 1'b0};
  assign cfg_r = '{kp: kp_roll_q, ki: ki_roll_q, kd: kd_roll_q, yaw: 1'b0};
  assign cfg_y = '{kp: yaw_gains_q[15:0], ki: yaw_gains_q[31:16],
                   kd: yaw_gains_q[47:32], yaw: 1'b1};

  assign in_ready_o = !busy_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign ack        = !out_valid_q || out_ready_i;
  assign env_any    = env_p || env_r || env_y;

  qapm_lane u_lane_pitch (
    .clk_i, .rst_ni, .start_i(in_xfer), .hold_i(fault_q),
    .angle_i(pitch_angle_i), .rate_i(pitch_rate_i), .cfg_i(cfg_p),
    .env_fault_o(env_p), .valid_o(vp), .axis_o(ax_p)
  );

  qapm_lane u_lane_roll (
    .clk_i, .rst_ni, .start_i(in_xfer), .hold_i(fault_q),
    .angle_i(roll_angle_i), .rate_i(roll_rate_i), .cfg_i(cfg_r),
    .env_fault_o(env_r), .valid_o(vr), .axis_o(ax_r)
  );

  qapm_lane u_lane_yaw (
    .clk_i, .rst_ni, .start_i(in_xfer), .hold_i(fault_q),
    .angle_i(yaw_angle_i), .rate_i(yaw_rate_i), .cfg_i(cfg_y),
    .env_fault_o(env_y), .valid_o(vy), .axis_o(ax_y)
  );

  qapm_mixer u_mixer (
    .clk_i, .rst_ni, .start_i(vp && vr && vy), .ack_i(ack),
    .p_i(ax_p), .r_i(ax_r), .y_i(ax_y), .base_i(base_q),
    .done_o(mix_done), .duty_o(mix_duty)
  );

  // Sequence control and fault latch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      fault_q      <= 1'b0;
      item_fault_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_q       <= 1'b1;
        fault_q      <= fault_q || env_any;
        item_fault_q <= fault_q || env_any;
      end else if (mix_done && ack) begin
        busy_q <= 1'b0;
      end
      if (mix_done && ack) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the output register, forcing the fault duty
  always_ff @(posedge clk_i) begin
    if (mix_done && ack) begin
      for (int k = 0; k < NumMotors; k++) begin
        duty_q[k] <= item_fault_q ? FaultDuty : mix_duty[k];
      end
      fault_out_q <= item_fault_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign motor_one_duty_o   = duty_q[0];
  assign motor_two_duty_o   = duty_q[1];
  assign motor_three_duty_o = duty_q[2];
  assign motor_four_duty_o  = duty_q[3];
  assign fault_tripped_o    = fault_out_q;

endmodule

FILE: rtl/qapm_checker.sv
module qapm_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [qapm_pkg::DutyW-1:0]        motor_one_duty_o,
  input logic [qapm_pkg::DutyW-1:0]        motor_two_duty_o,
  input logic [qapm_pkg::DutyW-1:0]        motor_three_duty_o,
  input logic [qapm_pkg::DutyW-1:0]        motor_four_duty_o,
  input logic                              fault_tripped_o
);
  import qapm_pkg::*;

  logic seen_fault_q;

  // Remember a transferred faulted result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_fault_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && fault_tripped_o) begin
      seen_fault_q <= 1'b1;
    end
  end

  // One sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sample taken while another is in flight");

  // Fault stays latched across results
  a_fault_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_fault_q |-> fault_tripped_o)
    else $error("fault cleared without reset");

  // Faulted results carry the fault duty on every motor
  a_fault_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_tripped_o |->
      motor_one_duty_o == FaultDuty && motor_two_duty_o == FaultDuty &&
      motor_three_duty_o == FaultDuty && motor_four_duty_o == FaultDuty)
    else $error("faulted result without fault duty");

  // Stalled result holds its valid, motor one duty and fault flag
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(motor_one_duty_o) && $stable(fault_tripped_o))
    else $error("stalled result changed");

endmodule

bind quad_attitude_pid_mixer qapm_checker u_checker (.*);
